@@ hw/rtl/epm_pkg.sv @@
// shared constants and types for the exact pattern matcher
package epm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 7;
    localparam int PIDX_W      = 6;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int ADDR_W      = ((IDX_W > PIDX_W) ? IDX_W : PIDX_W) + 1;
    localparam int CMP_W       = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TEXT = 2'd1,
        ACT_NEW  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef struct packed {
        logic              win_shift;
        logic              pat_rot;
        logic [BYTE_W-1:0] data;
    } t_cell_ctl;

endpackage

@@ hw/rtl/epm_cell.sv @@
// one matcher cell: a window byte, a pattern byte and their compare
module epm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  epm_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_load,
    input  logic                        i_active,
    input  logic [epm_pkg::BYTE_W-1:0]  i_win_prev,
    input  logic [epm_pkg::BYTE_W-1:0]  i_pat_prev,
    output logic [epm_pkg::BYTE_W-1:0]  o_win,
    output logic [epm_pkg::BYTE_W-1:0]  o_pat,
    output logic                        o_hit
);
    import epm_pkg::*;

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;

    // window shifts toward higher cells, newest byte in cell 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctl.win_shift) begin
            r_win <= i_win_prev;
        end
    end

    // pattern ring rotates by one cell, or takes a loaded byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_rot) begin
            r_pat <= i_pat_prev;
        end else if (i_load) begin
            r_pat <= i_ctl.data;
        end
    end

    assign o_win = r_win;
    assign o_pat = r_pat;
    assign o_hit = !i_active || (r_win == r_pat);

endmodule

@@ hw/rtl/exact_pattern_matcher.sv @@
// exact byte-pattern matcher top level: cell chain, text counter and result stages
//
// Input channel: one word per accepted item (action, pattern_index, data_byte),
// taken when i_in_valid is high and o_in_stall is low. A load writes one pattern
// byte, a text byte shifts into the window, a new-text action clears the count.
// Every item gives exactly one result word on the output channel, taken when
// o_out_valid is high and i_out_stall is low.
// An item goes from acceptance through the compare stage and the output register to
// o_out_valid. Throughput is one item per cycle while no stall or rotation holds it.
// A stalled receiver holds the output register; one more item is taken into the
// compare stage, then o_in_stall rises until the output moves.
// pattern_length is written on the cfg channel (always ready). After a write the
// pattern ring rotates one cell per cycle to the new alignment, with o_in_stall
// high. Reset sets the length to 1, clears the window and count and empties
// both stages; reset needs no clearing pass.
module exact_pattern_matcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [epm_pkg::PIDX_W-1:0]   i_pattern_index,
    input  logic [epm_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_match_found,
    output logic [epm_pkg::COUNT_W-1:0]  o_match_start,
    output logic                         o_position_overflow,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [epm_pkg::LEN_W-1:0]    i_cfg_data
);
    import epm_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   len_eff;
    logic [IDX_W-1:0]   rot_tgt;
    logic [IDX_W-1:0]   r_rot;
    logic               busy;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               in_acc;
    logic               s1_adv;
    logic               cfg_acc;
    logic               is_text;
    logic               is_load;
    logic [ADDR_W-1:0]  ld_sum;
    logic [ADDR_W-1:0]  ld_addr;
    logic               ld_ok;
    t_cell_ctl          ctl;
    logic [BYTE_W-1:0]  win [MAX_PATTERN];
    logic [BYTE_W-1:0]  pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] load_sel;
    logic [MAX_PATTERN-1:0] active;

    logic               r_s1_valid;
    logic               r_s1_text;
    logic               r_s1_gate;
    logic               r_s1_ovf;
    logic [COUNT_W-1:0] r_s1_start;
    logic               r_out_valid;
    logic               r_out_found;
    logic [COUNT_W-1:0] r_out_start;
    logic               r_out_ovf;
    logic               found;

    always_comb begin
        len_eff = r_len;
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (CMP_W'(r_len) > CMP_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
    end

    assign rot_tgt = IDX_W'(len_eff - LEN_W'(1));
    assign busy    = (r_rot != rot_tgt);
    assign s1_adv  = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy || (r_s1_valid && !s1_adv);
    assign in_acc  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign is_text = (i_action == ACT_TEXT);
    assign is_load = (i_action == ACT_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (cfg_acc) begin
            r_len <= i_cfg_data;
        end
    end

    // ring offset: cell j holds pattern byte (r_rot - j) mod depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= '0;
        end else if (busy) begin
            r_rot <= (ADDR_W'(r_rot) == ADDR_W'(MAX_PATTERN - 1)) ? '0 : r_rot + IDX_W'(1);
        end
    end

    // load slot address in the rotated ring
    assign ld_sum  = ADDR_W'(r_rot) + ADDR_W'(MAX_PATTERN) - ADDR_W'(i_pattern_index);
    assign ld_addr = (ld_sum >= ADDR_W'(MAX_PATTERN)) ? ld_sum - ADDR_W'(MAX_PATTERN) : ld_sum;
    assign ld_ok   = in_acc && is_load && (ADDR_W'(i_pattern_index) < ADDR_W'(MAX_PATTERN));

    always_comb begin
        ctl.win_shift = in_acc && is_text;
        ctl.pat_rot   = busy;
        ctl.data      = i_data_byte;
    end

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        assign load_sel[j] = ld_ok && (ld_addr == ADDR_W'(j));
        assign active[j]   = (CMP_W'(j) < CMP_W'(len_eff));

        epm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_load     (load_sel[j]),
            .i_active   (active[j]),
            .i_win_prev ((j == 0) ? i_data_byte : win[(j + MAX_PATTERN - 1) % MAX_PATTERN]),
            .i_pat_prev (pat[(j + MAX_PATTERN - 1) % MAX_PATTERN]),
            .o_win      (win[j]),
            .o_pat      (pat[j]),
            .o_hit      (hit[j])
        );
    end

    always_comb begin
        n_count = r_count;
        unique case (i_action)
            ACT_TEXT: begin
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            ACT_NEW:  n_count = '0;
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= n_count;
        end
    end

    // compare stage: window and ring are settled when the item arrives here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_text  <= is_text;
            r_s1_gate  <= (n_count >= COUNT_W'(len_eff));
            r_s1_ovf   <= (n_count == COUNT_MAX);
            r_s1_start <= r_count - COUNT_W'(len_eff - LEN_W'(1));
        end
    end

    assign found = r_s1_text && r_s1_gate && (&hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_found <= found;
            r_out_start <= found ? r_s1_start : '0;
            r_out_ovf   <= r_s1_ovf;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_match_found       = r_out_found;
    assign o_match_start       = r_out_start;
    assign o_position_overflow = r_out_ovf;

    a_no_accept_while_rotating: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) in_acc |-> (r_rot == rot_tgt)
    ) else $error("item accepted while pattern ring misaligned");

    a_no_overrun: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (r_s1_valid && !s1_adv) |-> !in_acc
    ) else $error("compare stage overwritten while blocked");

    a_count_sticks: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_count == COUNT_MAX && !(in_acc && i_action == ACT_NEW)) |=> (r_count == COUNT_MAX)
    ) else $error("saturated text count moved without new text");

    a_cfg_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) cfg_acc |=> (r_len == $past(i_cfg_data))
    ) else $error("pattern length not taken");

endmodule
